FILE: rtl/xasr_pkg.sv
// Shared types, constants and coefficient table for the six-to-seven audio resampler.
package xasr_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 16;
    localparam int PROD_W       = SAMPLE_W + COEF_W;
    localparam int QUOT_W       = PROD_W - 15;
    localparam int ACC_W        = 22;
    localparam int TAP_COUNT    = 29;
    localparam int PHASE_COUNT  = 7;
    localparam int TAP_W        = 5;
    localparam int PHASE_W      = 3;
    localparam int CNT_W        = 3;

    localparam logic [CNT_W-1:0]   BURST_PERIOD = 3'd6;
    localparam logic [TAP_W-1:0]   LAST_TAP     = 5'(TAP_COUNT - 1);
    localparam logic [PHASE_W-1:0] LAST_PHASE   = 3'(PHASE_COUNT - 1);
    localparam logic [PROD_W-1:0]  ROUND_BIAS   = 32'h0000_7FFF;
    localparam logic signed [ACC_W-1:0] SAT_MAX = 22'sd32767;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -22'sd32768;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_OUT
    } t_state;

    typedef logic signed [COEF_W-1:0] t_coef;

    localparam t_coef COEF_ROM [PHASE_COUNT][TAP_COUNT] = '{
        '{ 16'sh0000,  16'sh0000,  16'sh0000,  16'sh0000,  16'sh0000, -16'sh0002,
           16'sh000a, -16'sh0022,  16'sh0041, -16'sh0054,  16'sh0034,  16'sh0009,
          -16'sh010a,  16'sh0400, -16'sh0a78,  16'sh234c,  16'sh6794, -16'sh1780,
           16'sh0bcd, -16'sh0623,  16'sh0350, -16'sh016d,  16'sh006b,  16'sh000a,
          -16'sh0010,  16'sh0011, -16'sh0008,  16'sh0003, -16'sh0001 },
        '{ 16'sh0000,  16'sh0000,  16'sh0000, -16'sh0002,  16'sh0000,  16'sh0003,
          -16'sh0013,  16'sh003c, -16'sh004b,  16'sh00a2, -16'sh00e3,  16'sh0132,
          -16'sh0043, -16'sh0267,  16'sh0c9d,  16'sh74bb, -16'sh11b4,  16'sh09b8,
          -16'sh05bf,  16'sh0372, -16'sh01a8,  16'sh00a6, -16'sh001b,  16'sh0005,
           16'sh0006, -16'sh0008,  16'sh0003, -16'sh0001,  16'sh0000 },
        '{ 16'sh0000,  16'sh0000, -16'sh0001,  16'sh0003, -16'sh0002, -16'sh0005,
           16'sh001f, -16'sh004a,  16'sh00b3, -16'sh0192,  16'sh02b1, -16'sh039e,
           16'sh04f8, -16'sh05a6,  16'sh7939, -16'sh05a6,  16'sh04f8, -16'sh039e,
           16'sh02b1, -16'sh0192,  16'sh00b3, -16'sh004a,  16'sh001f, -16'sh0005,
          -16'sh0002,  16'sh0003, -16'sh0001,  16'sh0000,  16'sh0000 },
        '{ 16'sh0000, -16'sh0001,  16'sh0003, -16'sh0008,  16'sh0006,  16'sh0005,
          -16'sh001b,  16'sh00a6, -16'sh01a8,  16'sh0372, -16'sh05bf,  16'sh09b8,
          -16'sh11b4,  16'sh74bb,  16'sh0c9d, -16'sh0267, -16'sh0043,  16'sh0132,
          -16'sh00e3,  16'sh00a2, -16'sh004b,  16'sh003c, -16'sh0013,  16'sh0003,
           16'sh0000, -16'sh0002,  16'sh0000,  16'sh0000,  16'sh0000 },
        '{-16'sh0001,  16'sh0003, -16'sh0008,  16'sh0011, -16'sh0010,  16'sh000a,
           16'sh006b, -16'sh016d,  16'sh0350, -16'sh0623,  16'sh0bcd, -16'sh1780,
           16'sh6794,  16'sh234c, -16'sh0a78,  16'sh0400, -16'sh010a,  16'sh0009,
           16'sh0034, -16'sh0054,  16'sh0041, -16'sh0022,  16'sh000a, -16'sh0001,
           16'sh0000,  16'sh0001,  16'sh0000,  16'sh0000,  16'sh0000 },
        '{ 16'sh0002, -16'sh0008,  16'sh0010, -16'sh0023,  16'sh002b,  16'sh001a,
          -16'sh00eb,  16'sh027b, -16'sh0548,  16'sh0afa, -16'sh16fa,  16'sh53e0,
           16'sh3c07, -16'sh1249,  16'sh080e, -16'sh0347,  16'sh015b, -16'sh0044,
          -16'sh0017,  16'sh0046, -16'sh0023,  16'sh0011, -16'sh0005,  16'sh0000,
           16'sh0000,  16'sh0000,  16'sh0000,  16'sh0000,  16'sh0000 },
        '{-16'sh0005,  16'sh0011, -16'sh0023,  16'sh0046, -16'sh0017, -16'sh0044,
           16'sh015b, -16'sh0347,  16'sh080e, -16'sh1249,  16'sh3c07,  16'sh53e0,
          -16'sh16fa,  16'sh0afa, -16'sh0548,  16'sh027b, -16'sh00eb,  16'sh001a,
           16'sh002b, -16'sh0023,  16'sh0010, -16'sh0008,  16'sh0002,  16'sh0000,
           16'sh0000,  16'sh0000,  16'sh0000,  16'sh0000,  16'sh0000 }
    };

    function automatic t_coef coef_lookup(input logic [PHASE_W-1:0] phase,
                                          input logic [TAP_W-1:0] tap);
        t_coef c;
        c = '0;
        if (phase <= LAST_PHASE && tap <= LAST_TAP) begin
            c = COEF_ROM[phase][tap];
        end
        return c;
    endfunction

endpackage

FILE: rtl/xa_audio_six_to_seven_resampler.sv
// Six-to-seven audio resampler: sample ring, tap sequencer and one shared MAC.
// An input that does not complete a group of six is written to the ring while the block stays idle.
// The sixth input starts a burst of seven outputs; each output issues all 29 taps
// to the single multiply-accumulate unit, drains the product pipeline (r_v1, r_v2)
// and then waits for its transaction before the next output of the burst starts.
// Reset clears the control state and the ring valid bits; empty entries read as zero.
module xa_audio_six_to_seven_resampler
    import xasr_pkg::*;
#(
    parameter int RING_DEPTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic                       o_last
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

    t_state r_state, n_state;

    logic signed [SAMPLE_W-1:0] r_ring [RING_DEPTH];
    logic [RING_DEPTH-1:0]      r_ring_vld;

    logic [AW-1:0]      r_wp;
    logic [CNT_W-1:0]   r_cnt;
    logic [TAP_W-1:0]   r_tap;
    logic [PHASE_W-1:0] r_phase;

    logic                       r_v1, r_v2;
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic                       r_rd_vld;
    t_coef                      r_coef;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_out;

    logic                       in_acc, out_acc, fire, issue, start_phase;
    logic [AW-1:0]              rd_addr, tap_ext, wp_inc;
    logic signed [SAMPLE_W-1:0] mul_a;
    logic [PROD_W-1:0]          biased;
    logic signed [QUOT_W-1:0]   quot;
    logic signed [SAMPLE_W-1:0] sat_val;

    assign in_acc  = i_in_valid & o_in_ready;
    assign out_acc = o_out_valid & i_out_ready;
    assign fire    = in_acc && (r_cnt == CNT_W'(1));
    assign issue   = (r_state == ST_MAC);
    assign start_phase = fire || (out_acc && (r_phase != LAST_PHASE));

    assign tap_ext = AW'(r_tap);
    assign rd_addr = (r_wp >= tap_ext) ? (r_wp - tap_ext)
                                       : AW'(RING_DEPTH + int'(r_wp) - int'(tap_ext));
    assign wp_inc  = (r_wp == LAST_ADDR) ? '0 : r_wp + AW'(1);

    assign mul_a  = r_rd_vld ? r_rd_data : '0;
    assign biased = r_prod[PROD_W-1] ? (PROD_W'(r_prod) + ROUND_BIAS) : PROD_W'(r_prod);
    assign quot   = QUOT_W'(biased[PROD_W-1:15]);

    always_comb begin
        if (r_acc > SAT_MAX) begin
            sat_val = SAMPLE_W'(SAT_MAX);
        end else if (r_acc < SAT_MIN) begin
            sat_val = SAMPLE_W'(SAT_MIN);
        end else begin
            sat_val = SAMPLE_W'(r_acc);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (fire) n_state = ST_MAC;
            end
            ST_MAC: begin
                if (r_tap == LAST_TAP) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!r_v1 && !r_v2) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_acc) n_state = (r_phase == LAST_PHASE) ? ST_IDLE : ST_MAC;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        o_out_valid = (r_state == ST_OUT);
        o_last      = (r_state == ST_OUT) && (r_phase == LAST_PHASE);
    end

    assign o_sample_out = r_out;

    always_ff @(posedge i_clk) begin
        if (in_acc) r_ring[r_wp] <= i_sample_in;
        r_rd_data <= r_ring[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_coef <= coef_lookup(r_phase, r_tap);
        r_prod <= mul_a * r_coef;
        if (start_phase) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(quot);
        end
        if (r_state == ST_DRAIN && !r_v1 && !r_v2) r_out <= sat_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ring_vld <= '0;
            r_wp       <= '0;
            r_cnt      <= BURST_PERIOD;
            r_tap      <= '0;
            r_phase    <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_v1     <= issue;
            r_v2     <= r_v1;
            r_rd_vld <= r_ring_vld[rd_addr];
            if (in_acc) begin
                r_ring_vld[r_wp] <= 1'b1;
                r_cnt <= fire ? BURST_PERIOD : r_cnt - CNT_W'(1);
                if (!fire) r_wp <= wp_inc;
            end
            if (fire) r_phase <= '0;
            if (start_phase) begin
                r_tap <= '0;
            end else if (issue) begin
                r_tap <= r_tap + TAP_W'(1);
            end
            if (out_acc) begin
                if (r_phase == LAST_PHASE) begin
                    r_wp <= wp_inc;
                end else begin
                    r_phase <= r_phase + PHASE_W'(1);
                end
            end
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output handshakes open together");

    a_idle_after_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> o_in_ready)
        else $error("block not idle after final output of burst");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != CNT_W'(0)) && (r_cnt <= BURST_PERIOD))
        else $error("burst counter out of range");

    a_pipe_empty_at_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!r_v1 && !r_v2))
        else $error("output shown while products still in flight");

endmodule
